// ===== rtl/krwg_pkg.sv =====
// ----------------------------------------------------------------------------
// krwg_pkg
// Shared constants, codes and step functions of the KISS random word generator.
// ----------------------------------------------------------------------------
`default_nettype none

package krwg_pkg;

  // Default lag table depth
  localparam int unsigned LAG_DEPTH_DEF = 256;

  // Result buffer depth (power of two) and its fill-count width
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Seed register reset values
  localparam logic [63:0] XS_SEED_RST    = 64'd88172645463325252;
  localparam logic [63:0] LCG_SEED_RST   = 64'd1234567890987654321;
  localparam logic [63:0] CARRY_SEED_RST = 64'd0;
  localparam logic [8:0]  LAG_LEN_RST    = 9'd1;

  // Congruential multiplier 6906969069 = 2^32 + LCG_MUL_LO
  localparam logic [31:0] LCG_MUL_LO = 32'd2612001773;
  localparam logic [63:0] LCG_ADD    = 64'd13579;

  // Multiply-with-carry shifts (multiplier 2^28 - 1)
  localparam int unsigned MWC_SHL = 28;
  localparam int unsigned MWC_SHR = 36;

  // Xorshift shifts
  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 17;
  localparam int unsigned XS_C = 43;

  // Item opcodes
  typedef enum logic [1:0] {
    MODE_GEN    = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_RESEED = 2'd2
  } mode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_XS_SEED    = 2'd0,
    CFG_LCG_SEED   = 2'd1,
    CFG_CARRY_SEED = 2'd2,
    CFG_LAG_LEN    = 2'd3
  } cfg_idx_e;

  // x * 6906969069 + 13579 mod 2^64, built from two 32-bit constant products
  function automatic logic [63:0] lcg_step(input logic [63:0] x);
    logic [63:0] p_lo;
    logic [31:0] p_hi;
    p_lo = {32'd0, x[31:0]} * {32'd0, LCG_MUL_LO};
    p_hi = x[63:32] * LCG_MUL_LO;
    return p_lo + {p_hi + x[31:0], 32'd0} + LCG_ADD;
  endfunction

  // One xorshift round: left 13, right 17, left 43
  function automatic logic [63:0] xs_step(input logic [63:0] x);
    logic [63:0] t;
    t = x ^ (x << XS_A);
    t = t ^ (t >> XS_B);
    t = t ^ (t << XS_C);
    return t;
  endfunction

  // Low-bit mask for a keep count; zero keeps nothing, 64 and above keep all
  function automatic logic [63:0] keep_mask(input logic [6:0] keep);
    logic [63:0] m;
    if (keep >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << keep[5:0]) - 64'd1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kiss_random_word_generator.sv =====
// ----------------------------------------------------------------------------
// kiss_random_word_generator
// KISS-style 64-bit word source: lag-table multiply-with-carry, congruential
// and xorshift parts summed and masked to the requested low bits.
// ----------------------------------------------------------------------------
// Path: with the result buffer empty, a generate item passes the stage 1 and
//   stage 2 registers and the buffer (table read, carry step, sum into buffer).
// Throughput: one item per cycle while the buffer has room, set by the lag
//   table read-modify-write (one-deep write forwarding) and the carry recurrence.
// Reset: asynchronous, active low; seeds, states, position and buffers take
//   their reset values at once; the lag table holds no value until written.
`default_nettype none

module kiss_random_word_generator #(
  parameter int unsigned LAG_DEPTH = krwg_pkg::LAG_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  // Input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  table_slot_i,
  input  wire logic [63:0] table_word_i,
  input  wire logic [6:0]  keep_bits_i,
  // Result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      random_word_o
);

  localparam int unsigned AW = (LAG_DEPTH > 1) ? $clog2(LAG_DEPTH) : 1;
  localparam int unsigned UW = krwg_pkg::OUT_CNT_W + 1;

  // Configuration registers
  logic [63:0] xs_seed_q, lcg_seed_q, carry_seed_q;
  logic [8:0]  lag_len_q;

  // Generator state
  logic [63:0] xs_q, xs_d;
  logic [63:0] lcg_q, lcg_d;
  logic [63:0] carry_q, carry_d;
  logic [8:0]  pos_q, pos_d;

  // Stage 0 (accept)
  logic          accept;
  logic          gen0, upd0, wrt0, rsd0;
  logic          slot_ok;
  logic [8:0]    len_eff, rd_pos, pos_inc, nxt_pos;
  logic [AW-1:0] rd_addr;
  logic          fwd0;

  // Stage 1 (table data back, carry step, write back)
  logic          s1_gen_q, s1_upd_q, s1_wrt_q, s1_rsd_q, s1_fwd_q;
  logic [AW-1:0] s1_addr_q;
  logic [63:0]   s1_word_q;
  logic [6:0]    s1_keep_q;
  logic [63:0]   ram_rdata, d1, mwc_pre, mwc_out, carry_nxt, wdata1;
  logic          we1;
  logic [63:0]   last_wdata_q;

  // Stage 2 (final sum and mask)
  logic          s2_gen_q;
  logic [63:0]   s2_mwc_q, s2_part_q;
  logic [6:0]    s2_keep_q;
  logic [63:0]   word2;

  // Result buffer
  logic [krwg_pkg::OUT_CNT_W-1:0] fifo_cnt;
  logic [UW-1:0]                  used;

  // --------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_seed_q    <= krwg_pkg::XS_SEED_RST;
      lcg_seed_q   <= krwg_pkg::LCG_SEED_RST;
      carry_seed_q <= krwg_pkg::CARRY_SEED_RST;
      lag_len_q    <= krwg_pkg::LAG_LEN_RST;
    end else if (cfg_we_i) begin
      case (krwg_pkg::cfg_idx_e'(cfg_idx_i))
        krwg_pkg::CFG_XS_SEED:    xs_seed_q    <= cfg_wdata_i;
        krwg_pkg::CFG_LCG_SEED:   lcg_seed_q   <= cfg_wdata_i;
        krwg_pkg::CFG_CARRY_SEED: carry_seed_q <= cfg_wdata_i;
        krwg_pkg::CFG_LAG_LEN:    lag_len_q    <= cfg_wdata_i[8:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: decode the item
  assign accept  = in_valid_i & ~in_stall_o;
  assign slot_ok = ({24'd0, table_slot_i} < 32'(LAG_DEPTH));

  always_comb begin
    gen0 = 1'b0;
    wrt0 = 1'b0;
    rsd0 = 1'b0;
    case (krwg_pkg::mode_e'(mode_i))
      krwg_pkg::MODE_GEN:    gen0 = accept;
      krwg_pkg::MODE_WRITE:  wrt0 = accept & slot_ok;
      krwg_pkg::MODE_RESEED: rsd0 = accept;
      default: begin
      end
    endcase
  end

  // keep of zero gives a zero result and leaves the state alone
  assign upd0 = gen0 & (keep_bits_i != 7'd0);

  // Table position in use, clamped to the table depth
  always_comb begin
    if ({23'd0, lag_len_q} > 32'(LAG_DEPTH)) begin
      len_eff = 9'(LAG_DEPTH);
    end else begin
      len_eff = lag_len_q;
    end
    if (len_eff <= 9'd1 || pos_q >= len_eff) begin
      rd_pos = 9'd0;
    end else begin
      rd_pos = pos_q;
    end
    pos_inc = rd_pos + 9'd1;
    nxt_pos = (pos_inc >= len_eff) ? 9'd0 : pos_inc;
    rd_addr = AW'(rd_pos);
  end

  // Position, congruential and xorshift state advance at accept, or reload on reseed
  always_comb begin
    pos_d = pos_q;
    lcg_d = lcg_q;
    xs_d  = xs_q;
    if (upd0) begin
      pos_d = nxt_pos;
      lcg_d = krwg_pkg::lcg_step(lcg_q);
      xs_d  = krwg_pkg::xs_step(xs_q);
    end else if (rsd0) begin
      pos_d = 9'd0;
      lcg_d = lcg_seed_q;
      xs_d  = xs_seed_q;
    end
  end

  // Read collides with the write now in stage 1: take the written word instead
  assign fwd0 = upd0 & we1 & (s1_addr_q == rd_addr);

  // --------------------------------------------------------------------------
  // Lag table
  krwg_lag_ram #(
    .DEPTH(LAG_DEPTH)
  ) u_lag_ram (
    .clk_i  (clk_i),
    .we_i   (we1),
    .waddr_i(s1_addr_q),
    .wdata_i(wdata1),
    .re_i   (upd0),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_gen_q <= 1'b0;
      s1_upd_q <= 1'b0;
      s1_wrt_q <= 1'b0;
      s1_rsd_q <= 1'b0;
      s1_fwd_q <= 1'b0;
    end else begin
      s1_gen_q <= gen0;
      s1_upd_q <= upd0;
      s1_wrt_q <= wrt0;
      s1_rsd_q <= rsd0;
      s1_fwd_q <= fwd0;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q    <= upd0 ? rd_addr : AW'(table_slot_i);
    s1_word_q    <= table_word_i;
    s1_keep_q    <= keep_bits_i;
    last_wdata_q <= wdata1;
  end

  // Multiply-with-carry step: d * (2^28 - 1) + carry
  always_comb begin
    d1        = s1_fwd_q ? last_wdata_q : ram_rdata;
    mwc_pre   = (d1 << krwg_pkg::MWC_SHL) + carry_q;
    carry_nxt = (d1 >> krwg_pkg::MWC_SHR) - {63'd0, (mwc_pre < d1)};
    mwc_out   = mwc_pre - d1;
    we1       = s1_upd_q | s1_wrt_q;
    wdata1    = s1_upd_q ? mwc_out : s1_word_q;
  end

  always_comb begin
    carry_d = carry_q;
    if (s1_upd_q) begin
      carry_d = carry_nxt;
    end else if (s1_rsd_q) begin
      carry_d = carry_seed_q;
    end
  end

  // Generator state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_q    <= krwg_pkg::XS_SEED_RST;
      lcg_q   <= krwg_pkg::LCG_SEED_RST;
      carry_q <= '0;
      pos_q   <= '0;
    end else begin
      xs_q    <= xs_d;
      lcg_q   <= lcg_d;
      carry_q <= carry_d;
      pos_q   <= pos_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: lcg_q and xs_q already hold this item's new values in stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_gen_q <= 1'b0;
    end else begin
      s2_gen_q <= s1_gen_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mwc_q  <= mwc_out;
    s2_part_q <= lcg_q + xs_q;
    s2_keep_q <= s1_keep_q;
  end

  assign word2 = (s2_mwc_q + s2_part_q) & krwg_pkg::keep_mask(s2_keep_q);

  // --------------------------------------------------------------------------
  // Result buffer; stall input while buffered plus in-flight results fill it
  krwg_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s2_gen_q),
    .data_i (word2),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (random_word_o),
    .count_o(fifo_cnt)
  );

  assign used       = UW'(fifo_cnt) + UW'(s1_gen_q) + UW'(s2_gen_q);
  assign in_stall_o = (32'(used) >= krwg_pkg::OUT_DEPTH);

endmodule

`default_nettype wire

// ===== rtl/krwg_lag_ram.sv =====
// ----------------------------------------------------------------------------
// krwg_lag_ram
// Lag table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module krwg_lag_ram #(
  parameter int unsigned DEPTH = krwg_pkg::LAG_DEPTH_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [63:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [63:0]        rdata_o
);

  logic [63:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/krwg_out_fifo.sv =====
// ----------------------------------------------------------------------------
// krwg_out_fifo
// Small result buffer that decouples the pipeline from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module krwg_out_fifo (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic [63:0]                    data_i,
  output logic                                valid_o,
  input  wire logic                           stall_i,
  output logic [63:0]                         data_o,
  output logic [krwg_pkg::OUT_CNT_W-1:0]      count_o
);

  localparam int unsigned PW = $clog2(krwg_pkg::OUT_DEPTH);
  localparam int unsigned CW = krwg_pkg::OUT_CNT_W;

  logic [63:0]   mem_q [krwg_pkg::OUT_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o & ~stall_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/krwg_checker.sv =====
// ----------------------------------------------------------------------------
// krwg_checker
// Port-level checks of the random word generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module krwg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  mode_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] random_word_o
);

  // A stalled result item stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its word
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(random_word_o))
    else $error("result word changed while stalled");

  // An empty output means no buffered or in-flight result can block input
  a_no_stall_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // From empty, a new result must match a generate item accepted at the input
  a_gen_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && (mode_i == krwg_pkg::MODE_GEN), 3))
    else $error("result item without matching generate item");

endmodule

bind kiss_random_word_generator krwg_checker u_krwg_checker (.*);

`default_nettype wire

// ===== bench/kiss_word_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kiss_word_checker
// Watches the configuration port and both item channels of the KISS random
// word generator, predicts every generated word from its own copy of the
// lag table, carry, congruential and xorshift state, and compares each
// result item in order against the oldest predicted word.
// ----------------------------------------------------------------------------

module kiss_word_checker
  import krwg_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  table_slot_i,
  input  logic [63:0] table_word_i,
  input  logic [6:0]  keep_bits_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] random_word_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  localparam logic [63:0] LCG_MULT = 64'd6906969069;
  localparam logic [63:0] LCG_INC  = 64'd13579;

  // Predicted generator state
  logic [63:0] lag_mem [DEPTH];
  int unsigned lag_ptr;
  logic [63:0] xs_q, lcg_q, carry_q;
  logic [63:0] xs_seed_q, lcg_seed_q, carry_seed_q;
  logic [8:0]  lag_len_q;

  // Words predicted but not yet seen on the output
  logic [63:0] expected_words [$];

  int fails   = 0;
  int pending = 0;
  int checked = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign checked_o    = checked;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int unsigned len, slot;
    logic [63:0] d, mwc, word, want;
    logic [6:0]  keep;
    if (!rst_ni) begin
      xs_seed_q    = 64'd88172645463325252;
      lcg_seed_q   = 64'd1234567890987654321;
      carry_seed_q = '0;
      lag_len_q    = 9'd1;
      xs_q         = xs_seed_q;
      lcg_q        = lcg_seed_q;
      carry_q      = '0;
      lag_ptr      = 0;
      expected_words.delete();
    end else begin
      // Register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_XS_SEED:    xs_seed_q    = cfg_wdata_i;
          CFG_LCG_SEED:   lcg_seed_q   = cfg_wdata_i;
          CFG_CARRY_SEED: carry_seed_q = cfg_wdata_i;
          CFG_LAG_LEN:    lag_len_q    = cfg_wdata_i[8:0];
          default: ;
        endcase
      end

      // Accepted input item
      if (in_valid_i && !in_stall_i) begin
        case (mode_i)
          MODE_GEN: begin
            keep = keep_bits_i;
            if (keep == 7'd0) begin
              // nothing kept, state untouched
              word = '0;
            end else begin
              // table slot in use; short or zero length pins it to entry 0
              len = lag_len_q;
              if (len > DEPTH) len = DEPTH;
              if (len <= 1) begin
                len  = 1;
                slot = 0;
              end else begin
                slot = lag_ptr;
                if (slot >= len) slot = 0;
              end
              // multiply-with-carry, multiplier 2^28 - 1
              d       = lag_mem[slot];
              mwc     = (d << 28) + carry_q;
              carry_q = (d >> 36) - ((mwc < d) ? 64'd1 : 64'd0);
              mwc     = mwc - d;
              lag_mem[slot] = mwc;
              slot++;
              if (slot >= len) slot = 0;
              lag_ptr = slot;
              // congruential and xorshift parts
              lcg_q = lcg_q * LCG_MULT + LCG_INC;
              xs_q  = xs_q ^ (xs_q << 13);
              xs_q  = xs_q ^ (xs_q >> 17);
              xs_q  = xs_q ^ (xs_q << 43);
              word  = mwc + lcg_q + xs_q;
              if (keep < 7'd64) word = word & ((64'd1 << keep) - 64'd1);
            end
            expected_words.push_back(word);
          end
          MODE_WRITE: lag_mem[table_slot_i] = table_word_i;
          MODE_RESEED: begin
            xs_q    = xs_seed_q;
            lcg_q   = lcg_seed_q;
            carry_q = carry_seed_q;
            lag_ptr = 0;
          end
          default: ; // unused opcode: no result, no state change
        endcase
      end

      // Accepted result item
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected random_word, expected none, actual %h",
                   $time, random_word_i);
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (random_word_i !== want) begin
            fails++;
            $display("%0t: random_word mismatch, expected %h, actual %h",
                     $time, want, random_word_i);
          end
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== bench/tb_kiss_random_word_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kiss_random_word_generator
// Drives the KISS random word generator with a directed opening (field
// extremes, every opcode, length and seed corner cases) followed by random
// configuration phases of mixed items under bursty input and stalled output.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------

module tb_kiss_random_word_generator;
  import krwg_pkg::*;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         ITEM_TARGET    = 1950;
  localparam int         SETTLE_CYCLES  = 12;
  localparam int         LONG_HOLD      = 300;
  localparam int         PRESSURE_ITEMS = 40;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  cfg_idx_e    cfg_idx_i   = CFG_XS_SEED;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  mode_i      = MODE_GEN;
  logic [7:0]  table_slot_i = '0;
  logic [63:0] table_word_i = '0;
  logic [6:0]  keep_bits_i = 7'd64;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [63:0] random_word_o;

  int fail_count, pending, checked;

  // Stimulus bookkeeping
  bit          entry_ok [256];
  int          cur_len     = 1;
  int          burst_left  = 0;
  bit          gaps_on     = 1'b1;
  int          items_sent  = 0;
  int          n_gen       = 0;
  int          n_write     = 0;
  int          n_reseed    = 0;
  int          n_ignored   = 0;
  int          phases      = 0;
  int          hold_req    = 0;
  int          hold_done   = 0;

  kiss_random_word_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .table_slot_i  (table_slot_i),
    .table_word_i  (table_word_i),
    .keep_bits_i   (keep_bits_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_o (random_word_o)
  );

  kiss_word_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .mode_i        (mode_i),
    .table_slot_i  (table_slot_i),
    .table_word_i  (table_word_i),
    .keep_bits_i   (keep_bits_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_i (random_word_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Keep count: mostly full width, often narrow, sometimes zero or above 64
  function automatic logic [6:0] pick_keep();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 7'd64;
    if (r < 7) return 7'($urandom_range(1, 8));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [63:0] pick_seed();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return rand64();
  endfunction

  // Offer one item; bursts of random length, separated by random gaps when on
  task automatic push_item(input logic [1:0] mode, input logic [7:0] slot,
                           input logic [63:0] word, input logic [6:0] keep);
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        repeat (gap) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
        end
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    table_slot_i <= slot;
    table_word_i <= word;
    keep_bits_i  <= keep;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic send_gen(input logic [6:0] keep);
    push_item(MODE_GEN, 8'($urandom), rand64(), keep);
    n_gen++;
  endtask

  task automatic send_write(input logic [7:0] slot, input logic [63:0] word);
    push_item(MODE_WRITE, slot, word, 7'($urandom));
    entry_ok[slot] = 1'b1;
    n_write++;
  endtask

  task automatic send_reseed();
    push_item(MODE_RESEED, 8'($urandom), rand64(), 7'($urandom));
    n_reseed++;
  endtask

  task automatic send_ignored();
    push_item(MODE_UNUSED, 8'($urandom), rand64(), 7'($urandom));
    n_ignored++;
  endtask

  // Drop valid, wait for every predicted word, then let the pipeline drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Length register; zero behaves as one, beyond depth as full depth
  task automatic set_length(input logic [63:0] data);
    int eff;
    cfg_write(CFG_LAG_LEN, data);
    eff = data[8:0];
    if (eff == 0) eff = 1;
    if (eff > 256) eff = 256;
    cur_len = eff;
  endtask

  // Make sure every entry the generator can read holds a value
  task automatic fill_table();
    for (int i = 0; i < cur_len; i++) begin
      if (!entry_ok[i]) send_write(8'(i), rand64());
    end
  endtask

  // Receiver: stall styles per segment, plus a long hold-off on request
  initial begin : receiver
    int style, seg, hold_left;
    hold_left = 0;
    forever begin
      style = $urandom_range(0, 3);
      seg   = $urandom_range(10, 150);
      repeat (seg) begin
        @(negedge clk_i);
        if (hold_req != hold_done) begin
          hold_done = hold_req;
          hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_stall_i <= 1'b1;
        end else begin
          case (style)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= 1'($urandom_range(0, 1));
            2:       out_stall_i <= ($urandom_range(0, 3) == 0);
            default: out_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int r, n;
    logic [63:0] len_data;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: keep extremes, every opcode, table entry extremes
    send_write(8'd0, '1);
    send_gen(7'd64);
    send_gen(7'd1);
    send_gen(7'd0);
    send_gen(7'd127);
    send_gen(7'd63);
    send_write(8'd0, '0);
    send_gen(7'd64);
    send_ignored();
    send_write(8'd255, rand64());
    send_reseed();
    send_gen(7'd64);
    settle();

    // Zero xorshift seed, all-ones seeds, zero length
    cfg_write(CFG_XS_SEED, '0);
    cfg_write(CFG_LCG_SEED, '1);
    cfg_write(CFG_CARRY_SEED, '1);
    set_length(64'd0);
    send_reseed();
    send_gen(7'd64);
    send_gen(7'd64);
    settle();

    // Length beyond the table depth
    set_length(64'd511);
    fill_table();
    repeat (3) send_gen(7'd64);
    settle();

    // Position left beyond a lowered length
    cfg_write(CFG_XS_SEED, 64'd88172645463325252);
    set_length(64'd4);
    send_reseed();
    repeat (3) send_gen(7'd64);
    settle();
    set_length(64'd2);
    repeat (3) send_gen(7'd64);
    settle();

    // Random phases
    while (items_sent < ITEM_TARGET) begin
      phases++;
      if (phases == 1 || $urandom_range(0, 1)) cfg_write(CFG_XS_SEED, pick_seed());
      if (phases == 1 || $urandom_range(0, 1)) cfg_write(CFG_LCG_SEED, pick_seed());
      if (phases == 1 || $urandom_range(0, 1)) cfg_write(CFG_CARRY_SEED, pick_seed());
      if (phases == 1 || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 9);
        if (r < 4)       len_data = 64'($urandom_range(1, 8));
        else if (r < 6)  len_data = 64'($urandom_range(9, 64));
        else if (r == 6) len_data = 64'd256;
        else if (r == 7) len_data = 64'($urandom_range(0, 1));
        else if (r == 8) len_data = 64'($urandom_range(257, 511));
        else             len_data = 64'($urandom_range(65, 255));
        // junk above the register width must be dropped
        if ($urandom_range(0, 1)) len_data = {rand64() >> 9, len_data[8:0]};
        set_length(len_data);
      end
      fill_table();
      if ($urandom_range(0, 1)) send_reseed();
      gaps_on = ($urandom_range(0, 3) != 0);

      // Back pressure: receiver holds off while items keep coming
      if (phases == 3) begin
        hold_req++;
        gaps_on = 1'b0;
        repeat (PRESSURE_ITEMS) send_gen(7'd64);
        settle();
      end

      n = $urandom_range(40, 160);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 74)      send_gen(pick_keep());
        else if (r < 86) send_write(8'($urandom), rand64());
        else if (r < 95) send_reseed();
        else             send_ignored();
      end
      settle();
    end

    $display("Covered %0d items: %0d generate, %0d table write, %0d reseed, %0d unused opcode",
             items_sent + n_ignored, n_gen, n_write, n_reseed, n_ignored);
    $display("%0d words checked over %0d random configuration phases", checked, phases);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
